FILE: rtl/core/ofsn_pkg.sv
// package for the surface normal orientation block
// constants, arctangent table and shared types; no dependencies
package ofsn_pkg;

	localparam int CordicSteps = 16;
	localparam int NormalWidth = 16;
	localparam int TabLen = 24;
	localparam int Steps = (CordicSteps < TabLen) ? CordicSteps : TabLen;

	// datapath width: 15 bit input scaled by 2^NormalWidth plus cordic growth
	localparam int DW = 15 + NormalWidth + 4;
	// angle width: degrees * 2^16 up to about +-1024 degrees
	localparam int AW = 27;

	localparam int GainQ20 = 636752;
	localparam int AngLimit = 23040;
	localparam int FullTurn = 46080;
	localparam int QuarterTurn = 11520;
	localparam int DegUnit = 65536;

	typedef logic signed [DW-1:0] dat_t;
	typedef logic signed [AW-1:0] ang_t;

	function automatic ang_t atan_tab(input logic [4:0] i);
		ang_t r;
		case (i)
			5'd0: r = 27'sd2949120;
			5'd1: r = 27'sd1740967;
			5'd2: r = 27'sd919879;
			5'd3: r = 27'sd466945;
			5'd4: r = 27'sd234379;
			5'd5: r = 27'sd117304;
			5'd6: r = 27'sd58666;
			5'd7: r = 27'sd29335;
			5'd8: r = 27'sd14668;
			5'd9: r = 27'sd7334;
			5'd10: r = 27'sd3667;
			5'd11: r = 27'sd1833;
			5'd12: r = 27'sd917;
			5'd13: r = 27'sd458;
			5'd14: r = 27'sd229;
			5'd15: r = 27'sd115;
			5'd16: r = 27'sd57;
			5'd17: r = 27'sd29;
			5'd18: r = 27'sd14;
			5'd19: r = 27'sd7;
			5'd20: r = 27'sd4;
			5'd21: r = 27'sd2;
			5'd22: r = 27'sd1;
			default: r = '0;
		endcase
		return r;
	endfunction

	// everything that travels down the chain
	typedef struct packed {
		logic valid;
		logic func;
		logic signed [16:0] heading;
		// rotation unit
		dat_t rx;
		dat_t ry;
		ang_t ra;
		// roll vectoring (x = z, y = turned x)
		dat_t lx;
		dat_t ly;
		ang_t la;
		logic lz;
		// pitch vectoring
		dat_t px;
		dat_t py;
		ang_t pa;
		logic pz;
		// heading vectoring (x = normal_y, y = normal_x)
		dat_t hx;
		dat_t hy;
		ang_t ha;
		logic hz;
		// z kept for the second pass
		dat_t z;
	} cell_t;

	function automatic ang_t to_out(input ang_t a);
		logic signed [AW-1:0] s;
		logic signed [AW-10:0] r;
		s = a + ang_t'(256);
		r = s[AW-1:9];
		if (r > (AW-9)'(AngLimit)) r = (AW-9)'(AngLimit);
		if (r < -(AW-9)'(AngLimit)) r = -(AW-9)'(AngLimit);
		return ang_t'(r);
	endfunction

endpackage

FILE: rtl/core/ofsn_cell.sv
// one cordic step, in parallel, for those of the four units that are enabled
// depends on ofsn_pkg
module ofsn_cell (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic [4:0] idx,
	input  logic vec_en,
	input  logic rot_en,
	input  ofsn_pkg::cell_t d,
	output ofsn_pkg::cell_t q
);
	import ofsn_pkg::*;

	cell_t n;
	ang_t t;

	function automatic void vstep(input dat_t x, input dat_t y, input ang_t a,
		input logic [4:0] i, output dat_t ox, output dat_t oy, output ang_t oa);
		ang_t tt;
		tt = atan_tab(i);
		if (y >= 0) begin
			ox = x + (y >>> i); oy = y - (x >>> i); oa = a + tt;
		end else begin
			ox = x - (y >>> i); oy = y + (x >>> i); oa = a - tt;
		end
	endfunction

	always_comb begin
		n = d;
		t = atan_tab(idx);
		if (rot_en) begin
			if (d.ra >= 0) begin
				n.rx = d.rx - (d.ry >>> idx); n.ry = d.ry + (d.rx >>> idx);
				n.ra = d.ra - t;
			end else begin
				n.rx = d.rx + (d.ry >>> idx); n.ry = d.ry - (d.rx >>> idx);
				n.ra = d.ra + t;
			end
		end
		if (vec_en) begin
			if (!d.lz) vstep(d.lx, d.ly, d.la, idx, n.lx, n.ly, n.la);
			if (!d.pz) vstep(d.px, d.py, d.pa, idx, n.px, n.py, n.pa);
		end
		if (rot_en && !d.hz) vstep(d.hx, d.hy, d.ha, idx, n.hx, n.hy, n.ha);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else if (en) begin
			q <= n;
		end
	end
endmodule

FILE: rtl/core/orientation_from_surface_normal_top.sv
// top level: input prep, two chains of cordic cells, gain stage, output register
// depends on ofsn_pkg and ofsn_cell
//
// Fully pipelined: one normal is taken every cycle unless the output stalls;
// it passes the first chain, the gain register, the second chain and the
// output register. The first chain of cells turns the normal by minus the
// heading and, in parallel, finds the new heading; after the gain correction
// the second chain finds roll and pitch. The whole pipe advances when the
// output register is empty or being read, so ready follows the output side.
module orientation_from_surface_normal_top (
	input  logic clk,
	input  logic arst_n,
	input  logic valid_in,
	output logic ready_in,
	input  logic func,
	input  logic signed [16:0] heading_in,
	input  logic signed [14:0] normal_x,
	input  logic signed [14:0] normal_y,
	input  logic signed [14:0] normal_z,
	output logic valid_out,
	input  logic ready_out,
	output logic signed [16:0] heading_out,
	output logic signed [15:0] pitch_out,
	output logic signed [15:0] roll_out
);
	import ofsn_pkg::*;

	logic en;
	cell_t p0, g_d, g_s1, v0;
	cell_t c1 [0:Steps];
	cell_t c2 [0:Steps];
	logic signed [17:0] a0, a1;
	dat_t sx, sy, sz;
	logic signed [DW+20:0] mx, my;

	assign en = !valid_out || ready_out;
	assign ready_in = en;

	// quadrant prep for a vectoring unit
	function automatic void vprep(input dat_t x, input dat_t y, output dat_t ox,
		output dat_t oy, output ang_t oa, output logic oz);
		oz = (x == 0) && (y == 0);
		ox = x; oy = y; oa = '0;
		if (x < 0) begin
			if (y >= 0) begin
				ox = y; oy = -x; oa = ang_t'(90 * DegUnit);
			end else begin
				ox = -y; oy = x; oa = -ang_t'(90 * DegUnit);
			end
		end
	endfunction

	always_comb begin
		sx = dat_t'(normal_x) <<< NormalWidth;
		sy = dat_t'(normal_y) <<< NormalWidth;
		sz = dat_t'(normal_z) <<< NormalWidth;
		a1 = -18'(heading_in);
		a0 = a1;
		// a 17 bit heading lies within two turns, so one fold gives the remainder
		if (a0 >= 18'(FullTurn)) a0 = a0 - 18'(FullTurn);
		else if (a0 <= -18'(FullTurn)) a0 = a0 + 18'(FullTurn);
		if (a0 > 18'(AngLimit)) a0 = a0 - 18'(FullTurn);
		if (a0 <= -18'(AngLimit)) a0 = a0 + 18'(FullTurn);
		p0 = '0;
		p0.valid = valid_in;
		p0.func = func;
		p0.heading = heading_in;
		p0.z = sz;
		p0.rx = sx; p0.ry = sy;
		if (a0 > 18'(QuarterTurn)) begin
			p0.rx = -sx; p0.ry = -sy; a0 = a0 - 18'(AngLimit);
		end else if (a0 < -18'(QuarterTurn)) begin
			p0.rx = -sx; p0.ry = -sy; a0 = a0 + 18'(AngLimit);
		end
		p0.ra = ang_t'(a0) <<< 9;
		vprep(sy, sx, p0.hx, p0.hy, p0.ha, p0.hz);
	end

	assign c1[0] = p0;

	genvar gi;
	generate
		for (gi = 0; gi < Steps; gi++) begin : g_rot
			ofsn_cell u_cell (
				.clk(clk), .arst_n(arst_n), .en(en), .idx(5'(gi)),
				.vec_en(1'b0), .rot_en(1'b1), .d(c1[gi]), .q(c1[gi+1]));
		end
	endgenerate

	// gain correction, registered
	always_comb begin
		mx = (DW+21)'(c1[Steps].rx) * (DW+21)'(GainQ20);
		my = (DW+21)'(c1[Steps].ry) * (DW+21)'(GainQ20);
		g_d = c1[Steps];
		g_d.rx = dat_t'(mx >>> 20);
		g_d.ry = dat_t'(my >>> 20);
		g_d.ra = '0;
		g_d.lx = '0; g_d.ly = '0; g_d.la = '0; g_d.lz = 1'b0;
		g_d.px = '0; g_d.py = '0; g_d.pa = '0; g_d.pz = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) g_s1 <= '0;
		else if (en) g_s1 <= g_d;
	end

	always_comb begin
		v0 = g_s1;
		vprep(g_s1.z, g_s1.rx, v0.lx, v0.ly, v0.la, v0.lz);
		vprep(g_s1.z, g_s1.ry, v0.px, v0.py, v0.pa, v0.pz);
	end

	assign c2[0] = v0;

	generate
		for (gi = 0; gi < Steps; gi++) begin : g_vec
			ofsn_cell u_cell (
				.clk(clk), .arst_n(arst_n), .en(en), .idx(5'(gi)),
				.vec_en(1'b1), .rot_en(1'b0), .d(c2[gi]), .q(c2[gi+1]));
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_out <= 1'b0;
		else if (en) valid_out <= c2[Steps].valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			roll_out <= 16'(to_out(c2[Steps].la));
			pitch_out <= 16'(-to_out(c2[Steps].pa));
			heading_out <= c2[Steps].func ? 17'(-to_out(c2[Steps].ha))
				: c2[Steps].heading;
		end
	end
endmodule

FILE: rtl/core/ofsn_checker.sv
// port level checks for the orientation block
// depends on orientation_from_surface_normal_top (bound below)
module ofsn_port_checks (
	input logic clk,
	input logic arst_n,
	input logic valid_out,
	input logic ready_out,
	input logic ready_in,
	input logic signed [15:0] pitch_out,
	input logic signed [15:0] roll_out
);
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		ready_in == (!valid_out || ready_out)) else $error("ready mismatch");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_out && !ready_out |=> valid_out && $stable(roll_out))
		else $error("output dropped");
	a_roll: assert property (@(posedge clk) disable iff (!arst_n)
		valid_out |-> roll_out <= 16'sd23040 && roll_out >= -16'sd23040)
		else $error("roll range");
	a_pitch: assert property (@(posedge clk) disable iff (!arst_n)
		valid_out |-> pitch_out <= 16'sd23040 && pitch_out >= -16'sd23040)
		else $error("pitch range");
endmodule

bind orientation_from_surface_normal_top ofsn_port_checks u_ofsn_checker (
	.clk(clk), .arst_n(arst_n), .valid_out(valid_out), .ready_out(ready_out),
	.ready_in(ready_in), .pitch_out(pitch_out), .roll_out(roll_out));

FILE: dv/ofsn_checker.sv
// checker for the surface normal orientation block: watches both channels,
// predicts pitch, roll and heading in fixed point and compares in order
// depends on ofsn_pkg
`timescale 1ns / 1ps

module ofsn_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic valid_in,
	input  logic ready_in,
	input  logic func,
	input  logic signed [16:0] heading_in,
	input  logic signed [14:0] normal_x,
	input  logic signed [14:0] normal_y,
	input  logic signed [14:0] normal_z,
	input  logic valid_out,
	input  logic ready_out,
	input  logic signed [16:0] heading_out,
	input  logic signed [15:0] pitch_out,
	input  logic signed [15:0] roll_out,
	output int errors,
	output int pending,
	output int results_seen
);
	import ofsn_pkg::*;

	typedef struct packed {
		logic signed [16:0] heading;
		logic signed [15:0] pitch;
		logic signed [15:0] roll;
	} attitude_t;

	attitude_t attitude_q[$];

	localparam longint DegQ16 = 65536;

	function automatic longint arctan_q16(input int i);
		longint t[24];
		t = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
			14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};
		return t[i];
	endfunction

	// angle of the vector (x, y) by vectoring, degrees * 2^16
	function automatic longint vector_angle(input longint y, input longint x);
		longint acc, t, nx, ny;
		acc = 0;
		if (x == 0 && y == 0)
			return 0;
		if (x < 0) begin
			if (y >= 0) begin
				t = x; x = y; y = -t; acc = 90 * DegQ16;
			end else begin
				t = x; x = -y; y = t; acc = -90 * DegQ16;
			end
		end
		for (int i = 0; i < Steps; i++) begin
			if (y >= 0) begin
				nx = x + (y >>> i); ny = y - (x >>> i); acc += arctan_q16(i);
			end else begin
				nx = x - (y >>> i); ny = y + (x >>> i); acc -= arctan_q16(i);
			end
			x = nx; y = ny;
		end
		return acc;
	endfunction

	function automatic longint round_angle(input longint a);
		longint r;
		r = (a + 256) >>> 9;
		if (r > AngLimit) r = AngLimit;
		if (r < -AngLimit) r = -AngLimit;
		return r;
	endfunction

	function automatic attitude_t predict_attitude(input logic f, input logic signed [16:0] h,
		input logic signed [14:0] nx_in, input logic signed [14:0] ny_in,
		input logic signed [14:0] nz_in);
		longint x, y, z, a, ang, rx, ry, tx, ty;
		attitude_t r;
		x = longint'(nx_in) <<< NormalWidth;
		y = longint'(ny_in) <<< NormalWidth;
		z = longint'(nz_in) <<< NormalWidth;
		a = -longint'(h);
		a = a % FullTurn;
		if (a > AngLimit) a -= FullTurn;
		if (a <= -AngLimit) a += FullTurn;
		rx = x; ry = y;
		// past a quarter turn, flip the vector so the rotation converges
		if (a > QuarterTurn) begin
			rx = -rx; ry = -ry; a -= AngLimit;
		end
		if (a < -QuarterTurn) begin
			rx = -rx; ry = -ry; a += AngLimit;
		end
		ang = a * 512;
		for (int i = 0; i < Steps; i++) begin
			if (ang >= 0) begin
				tx = rx - (ry >>> i); ty = ry + (rx >>> i); ang -= arctan_q16(i);
			end else begin
				tx = rx + (ry >>> i); ty = ry - (rx >>> i); ang += arctan_q16(i);
			end
			rx = tx; ry = ty;
		end
		rx = (rx * GainQ20) >>> 20;
		ry = (ry * GainQ20) >>> 20;
		r.roll = 16'(round_angle(vector_angle(rx, z)));
		r.pitch = 16'(-round_angle(vector_angle(ry, z)));
		r.heading = f ? 17'(-round_angle(vector_angle(x, y))) : h;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		attitude_t e;
		if (!arst_n) begin
			errors <= 0;
			results_seen <= 0;
			attitude_q.delete();
		end else begin
			if (valid_in && ready_in)
				attitude_q.push_back(predict_attitude(func, heading_in, normal_x, normal_y,
					normal_z));
			if (valid_out && ready_out) begin
				results_seen <= results_seen + 1;
				if (attitude_q.size() == 0) begin
					$display("%0t: unexpected transfer h=%0d p=%0d r=%0d", $time,
						heading_out, pitch_out, roll_out);
					errors <= errors + 1;
				end else begin
					e = attitude_q.pop_front();
					if (e.heading !== heading_out || e.pitch !== pitch_out
						|| e.roll !== roll_out) begin
						$display("%0t: expected h=%0d p=%0d r=%0d, got h=%0d p=%0d r=%0d",
							$time, e.heading, e.pitch, e.roll, heading_out, pitch_out,
							roll_out);
						errors <= errors + 1;
					end
				end
			end
		end
	end

	assign pending = attitude_q.size();

endmodule

FILE: dv/tb_orientation_from_surface_normal_top.sv
// testbench top for the surface normal orientation block: directed and random
// normals under varying stalls; checking is done in ofsn_checker
// depends on ofsn_pkg, ofsn_checker and the block
`timescale 1ns / 1ps

module tb_orientation_from_surface_normal_top;
	import ofsn_pkg::*;

	localparam int Latency = 2 * Steps + 2;
	localparam int StallLimit = 20000;

	logic clk, arst_n;
	logic valid_in, ready_in, func, valid_out, ready_out;
	logic signed [16:0] heading_in, heading_out;
	logic signed [14:0] normal_x, normal_y, normal_z;
	logic signed [15:0] pitch_out, roll_out;
	int errors, pending, results_seen;
	int send_idle_pct, recv_idle_pct;
	int items_sent;
	bit hold_recv;
	int idle_cycles;

	orientation_from_surface_normal_top u_dut (.*);

	ofsn_checker u_chk (.*);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// receiver: random stalls, or a long hold-off when asked
	always @(negedge clk) begin
		if (hold_recv)
			ready_out <= 1'b0;
		else
			ready_out <= ($urandom_range(99) >= recv_idle_pct);
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (valid_in && ready_in) || (valid_out && ready_out))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > StallLimit) begin
			$display("orientation_from_surface_normal_top: mismatch");
			$finish;
		end
	end

	task automatic send_normal(input logic f, input logic signed [16:0] h,
		input logic signed [14:0] x, input logic signed [14:0] y,
		input logic signed [14:0] z);
		while ($urandom_range(99) < send_idle_pct) begin
			valid_in <= 0;
			@(negedge clk);
		end
		valid_in <= 1;
		func <= f;
		heading_in <= h;
		normal_x <= x;
		normal_y <= y;
		normal_z <= z;
		@(posedge clk);
		while (!ready_in)
			@(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	function automatic logic signed [14:0] rand_comp();
		case ($urandom_range(5))
			0: return -15'sd16384;
			1: return 15'sd16383;
			2: return 15'sd0;
			3: return 15'($urandom_range(64)) - 15'sd32;
			default: return 15'($urandom);
		endcase
	endfunction

	function automatic logic signed [16:0] rand_heading();
		case ($urandom_range(5))
			0: return 17'($urandom);
			1: return -17'sd46080;
			2: return 17'sd46079;
			default: return 17'($urandom_range(92159)) - 17'sd46080;
		endcase
	endfunction

	task automatic drain();
		valid_in <= 0;
		while (pending != 0)
			@(negedge clk);
		repeat (Latency + 4) @(negedge clk);
	endtask

	initial begin
		valid_in = 0; func = 0; heading_in = 0;
		normal_x = 0; normal_y = 0; normal_z = 0;
		hold_recv = 0; items_sent = 0;
		send_idle_pct = 0; recv_idle_pct = 0;
		arst_n = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: extremes, zero vectors, quarter-turn boundaries
		send_normal(1'b0, 17'sd0, 15'sd0, 15'sd0, 15'sd0);
		send_normal(1'b1, 17'sd0, 15'sd0, 15'sd0, 15'sd0);
		send_normal(1'b1, 17'sd0, 15'sd0, 15'sd0, 15'sd16383);
		send_normal(1'b1, 17'sd0, 15'sd16383, 15'sd0, 15'sd0);
		send_normal(1'b1, 17'sd0, -15'sd16384, 15'sd0, 15'sd0);
		send_normal(1'b1, 17'sd0, 15'sd0, -15'sd16384, 15'sd0);
		send_normal(1'b1, 17'sd0, -15'sd16384, -15'sd16384, -15'sd16384);
		send_normal(1'b1, 17'sd0, 15'sd16383, 15'sd16383, 15'sd16383);
		send_normal(1'b0, 17'sd11520, 15'sd1000, 15'sd2000, 15'sd16000);
		send_normal(1'b0, 17'sd11521, 15'sd1000, 15'sd2000, 15'sd16000);
		send_normal(1'b0, -17'sd11520, 15'sd1000, 15'sd2000, 15'sd16000);
		send_normal(1'b0, -17'sd11521, -15'sd1000, 15'sd2000, 15'sd16000);
		send_normal(1'b1, 17'sd23040, 15'sd3000, -15'sd4000, -15'sd9000);
		send_normal(1'b1, -17'sd23040, 15'sd3000, -15'sd4000, 15'sd9000);
		send_normal(1'b0, 17'sd46079, 15'sd5000, 15'sd5000, 15'sd10000);
		send_normal(1'b0, -17'sd46080, 15'sd5000, 15'sd5000, -15'sd10000);
		send_normal(1'b0, -17'sd65536, 15'sd7000, -15'sd7000, 15'sd100);
		send_normal(1'b0, 17'sd65535, -15'sd7000, 15'sd7000, -15'sd100);
		send_normal(1'b1, 17'sd0, -15'sd16384, 15'sd0, -15'sd1);
		send_normal(1'b1, 17'sd0, -15'sd1, -15'sd16384, -15'sd16384);
		drain();

		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 6 : (ph == 1) ? 56 : 0;
			recv_idle_pct = (ph == 0) ? 56 : (ph == 1) ? 6 : 0;
			for (int n = 0; n < 290; n++)
				send_normal(1'($urandom_range(1)), rand_heading(), rand_comp(),
					rand_comp(), rand_comp());
			drain();
		end

		// long receiver hold-off while the sender keeps offering
		fork
			begin
				hold_recv = 1;
				repeat (3 * Latency) @(negedge clk);
				hold_recv = 0;
			end
			for (int n = 0; n < 60; n++)
				send_normal(1'($urandom_range(1)), rand_heading(), rand_comp(),
					rand_comp(), rand_comp());
		join
		drain();

		$display("sent %0d normals with both func values, extreme headings and components,",
			items_sent);
		$display("  under sender/receiver stalls and a full-pipe hold-off; %0d results",
			results_seen);
		if (errors == 0)
			$display("orientation_from_surface_normal_top: match");
		else
			$display("orientation_from_surface_normal_top: mismatch");
		$finish;
	end

endmodule

FILE: files.f
rtl/core/ofsn_pkg.sv
rtl/core/ofsn_cell.sv
rtl/core/orientation_from_surface_normal_top.sv
rtl/core/ofsn_checker.sv
dv/ofsn_checker.sv
dv/tb_orientation_from_surface_normal_top.sv
